### hdl/modbus_rtu_slave_engine_core_assert.svh
// Assertion macros used by the checker file.
`ifndef MODBUS_RTU_SLAVE_ENGINE_CORE_ASSERT_SVH
`define MODBUS_RTU_SLAVE_ENGINE_CORE_ASSERT_SVH

// Plain clocked assertion, also checked while reset is applied.
`define MRSE_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

// Clocked assertion that is skipped while reset is applied.
`define MRSE_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`endif

### hdl/mrse_pkg.sv
// ----------------------------------------------------------------------------
// mrse_pkg
// Types, Modbus codes and the CRC-16 step shared by the slave engine.
// ----------------------------------------------------------------------------
package mrse_pkg;

    localparam logic [7:0]  FN_READ_HOLD  = 8'h03;
    localparam logic [7:0]  FN_WRITE_ONE  = 8'h06;
    localparam logic [7:0]  FN_WRITE_MULT = 8'h10;
    localparam logic [7:0]  FN_EXC_FLAG   = 8'h80;
    localparam logic [7:0]  EXC_ILL_FUNC  = 8'h01;
    localparam logic [7:0]  EXC_ILL_ADDR  = 8'h02;
    localparam logic [7:0]  EXC_ILL_VALUE = 8'h03;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [7:0]  BCAST_ADDR    = 8'h00;
    localparam int          MAX_WR_CNT    = 123;

    localparam logic CFG_SLAVE_ID    = 1'b0;
    localparam logic CFG_REGS_IN_USE = 1'b1;

    typedef struct packed {
        logic       mode;    // 1 = frame gap
        logic [7:0] data;
    } t_item;

    // front queue to back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

    // back end to front queue
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_q_ctl;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

### hdl/mrse_front.sv
// ----------------------------------------------------------------------------
// mrse_front
// Input side: takes stream items into a four-entry queue for the back end.
// ----------------------------------------------------------------------------
module mrse_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [7:0]      i_s_tdata,
    input  logic            i_s_tuser,
    input  mrse_pkg::t_q_ctl i_ctl,
    output mrse_pkg::t_q_out o_q
);
    import mrse_pkg::*;

    t_item      r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;

    assign o_s_tready = (r_cnt != 3'd4) && !i_ctl.clearing;
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = i_ctl.pop && (r_cnt != 3'd0);
    assign o_q.valid  = (r_cnt != 3'd0);
    assign o_q.item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{mode: i_s_tuser, data: i_s_tdata};
        end
    end

endmodule

### hdl/mrse_engine.sv
// ----------------------------------------------------------------------------
// mrse_engine
// Back end: frame buffer, request checks, register file and response output.
// ----------------------------------------------------------------------------
module mrse_engine #(
    parameter int FRAME_BYTES = 64,
    parameter int REG_DEPTH   = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mrse_pkg::t_q_out i_q,
    output mrse_pkg::t_q_ctl o_ctl,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [7:0]       i_cfg_wdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast
);
    import mrse_pkg::*;

    localparam int FA_W  = $clog2(FRAME_BYTES);
    localparam int LEN_W = $clog2(FRAME_BYTES + 1);
    localparam int RA_W  = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;

    typedef enum logic [7:0] {
        S_CLR    = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_CHECK  = 8'b0000_1000,
        S_WRD    = 8'b0001_0000,
        S_WGET   = 8'b0010_0000,
        S_TX     = 8'b0100_0000,
        S_RFETCH = 8'b1000_0000
    } t_state;

    typedef enum logic [2:0] {
        K_EXC  = 3'b001,
        K_ECHO = 3'b010,
        K_READ = 3'b100
    } t_kind;

    t_state r_st;
    t_kind  r_kind;
    logic [7:0]  r_slave_id;
    logic [6:0]  r_regs_in_use;

    logic [7:0]  r_frm [FRAME_BYTES];
    logic [15:0] r_regs [REG_DEPTH];
    logic [7:0]  r_frm_rd;
    logic [15:0] r_reg_rd;

    logic [LEN_W-1:0] r_len, r_ridx, r_sidx, r_j;
    logic             r_sv, r_ph, r_have;
    logic [RA_W-1:0]  r_clr, r_widx;
    logic [7:0]       r_f [7];
    logic [7:0]       r_crc_lo, r_crc_hi, r_hi, r_code;
    logic [15:0]      r_crc, r_tcrc, r_start;
    logic [8:0]       r_tidx, r_body;
    logic             r_bcast;

    logic [FA_W-1:0]  frm_raddr;
    logic [RA_W-1:0]  reg_raddr, reg_waddr;
    logic             reg_ren, reg_we;
    logic [15:0]      reg_wdata;

    logic             ovalid_n;
    logic [7:0]       obyte_n;
    logic             olast_n;

    // request fields seen in the check cycle
    logic [31:0] len32, lim32, start32, cnt32, bc32;
    logic        bcast, addr_ok, crc_ok;
    logic [8:0]  off;
    logic        need_fetch, slot_free;

    assign len32   = 32'(r_len);
    assign lim32   = (32'(r_regs_in_use) > 32'(REG_DEPTH)) ? 32'(REG_DEPTH)
                                                           : 32'(r_regs_in_use);
    assign start32 = {16'h0, r_f[2], r_f[3]};
    assign cnt32   = {16'h0, r_f[4], r_f[5]};
    assign bc32    = {24'h0, r_f[6]};
    assign bcast   = (r_f[0] == BCAST_ADDR);
    assign addr_ok = bcast || (r_f[0] == r_slave_id);
    assign crc_ok  = ({r_crc_hi, r_crc_lo} == r_crc);

    assign off        = r_tidx - 9'd3;
    assign need_fetch = (r_kind == K_READ) && (r_tidx >= 9'd3) && (r_tidx < r_body)
                        && !off[0] && !r_have;
    assign slot_free  = !o_m_tvalid || i_m_tready;

    assign o_ctl.pop      = (r_st == S_IDLE);
    assign o_ctl.clearing = (r_st == S_CLR);

    always_comb begin
        frm_raddr = r_ridx[FA_W-1:0];
        if (r_st == S_WRD) begin
            frm_raddr = r_j[FA_W-1:0];
        end
    end

    assign reg_ren   = (r_st == S_RFETCH);
    assign reg_raddr = RA_W'(r_start + {8'h0, off[8:1]});

    // response byte generator
    always_comb begin
        obyte_n = 8'h00;
        olast_n = 1'b0;
        if (r_tidx < r_body) begin
            unique case (r_kind)
                K_EXC: begin
                    if (r_tidx == 9'd0)      obyte_n = r_f[0];
                    else if (r_tidx == 9'd1) obyte_n = r_f[1] | FN_EXC_FLAG;
                    else                     obyte_n = r_code;
                end
                K_ECHO: obyte_n = r_f[r_tidx[2:0]];
                K_READ: begin
                    if (r_tidx == 9'd0)      obyte_n = r_f[0];
                    else if (r_tidx == 9'd1) obyte_n = FN_READ_HOLD;
                    else if (r_tidx == 9'd2) obyte_n = {r_f[5][6:0], 1'b0};
                    else                     obyte_n = off[0] ? r_reg_rd[7:0] : r_reg_rd[15:8];
                end
                default: obyte_n = 8'h00;
            endcase
        end else if (r_tidx == r_body) begin
            obyte_n = r_tcrc[7:0];
        end else begin
            obyte_n = r_tcrc[15:8];
            olast_n = 1'b1;
        end
    end

    assign ovalid_n = (r_st == S_TX) && !need_fetch;

    always_comb begin
        reg_we    = 1'b0;
        reg_waddr = r_widx;
        reg_wdata = {r_hi, r_frm_rd};
        priority if (r_st == S_CLR) begin
            reg_we    = 1'b1;
            reg_waddr = r_clr;
            reg_wdata = 16'h0;
        end else if (r_st == S_CHECK) begin
            reg_we    = addr_ok && crc_ok && (r_f[1] == FN_WRITE_ONE) && (len32 == 32'd8)
                        && (start32 < lim32);
            reg_waddr = RA_W'(start32);
            reg_wdata = {r_f[4], r_f[5]};
        end else if (r_st == S_WGET) begin
            reg_we    = r_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            r_regs[reg_waddr] <= reg_wdata;
        end
        if (reg_ren) begin
            r_reg_rd <= r_regs[reg_raddr];
        end
        if ((r_st == S_IDLE) && i_q.valid && !i_q.item.mode
                && (32'(r_len) < 32'(FRAME_BYTES))) begin
            r_frm[r_len[FA_W-1:0]] <= i_q.item.data;
        end
        r_frm_rd <= r_frm[frm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st          <= S_CLR;
            r_clr         <= '0;
            r_len         <= '0;
            r_sv          <= 1'b0;
            r_slave_id    <= 8'd1;
            r_regs_in_use <= 7'd64;
            o_m_tvalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SLAVE_ID)    r_slave_id    <= i_cfg_wdata;
                if (i_cfg_idx == CFG_REGS_IN_USE) r_regs_in_use <= i_cfg_wdata[6:0];
            end
            if (o_m_tvalid && i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + RA_W'(1);
                    if (r_clr == RA_W'(REG_DEPTH - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_q.valid) begin
                        if (!i_q.item.mode) begin
                            if (32'(r_len) < 32'(FRAME_BYTES)) r_len <= r_len + LEN_W'(1);
                            else                               r_len <= '0;
                        end else if (r_len > LEN_W'(4)) begin
                            r_st   <= S_SCAN;
                            r_ridx <= '0;
                            r_sv   <= 1'b0;
                            r_crc  <= CRC_INIT;
                        end else begin
                            r_len <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    r_sv   <= (r_ridx < r_len);
                    r_sidx <= r_ridx;
                    if (r_ridx < r_len) r_ridx <= r_ridx + LEN_W'(1);
                    if (r_sv) begin
                        if (r_sidx < r_len - LEN_W'(2)) r_crc <= crc_byte(r_crc, r_frm_rd);
                        for (int k = 0; k < 7; k++) begin
                            if (r_sidx == LEN_W'(k)) r_f[k] <= r_frm_rd;
                        end
                        if (r_sidx == r_len - LEN_W'(2)) r_crc_lo <= r_frm_rd;
                        if (r_sidx == r_len - LEN_W'(1)) begin
                            r_crc_hi <= r_frm_rd;
                            r_sv     <= 1'b0;
                            r_st     <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_st    <= S_IDLE;
                    r_len   <= '0;
                    r_tidx  <= '0;
                    r_tcrc  <= CRC_INIT;
                    r_have  <= 1'b0;
                    r_bcast <= bcast;
                    r_start <= start32[15:0];
                    r_kind  <= K_EXC;
                    r_body  <= 9'd3;
                    if (addr_ok && crc_ok) begin
                        r_st <= bcast ? S_IDLE : S_TX;
                        unique case (r_f[1])
                            FN_READ_HOLD: begin
                                if (bcast) begin
                                    r_st <= S_IDLE;
                                end else if (len32 != 32'd8
                                        || 32'd5 + 2 * cnt32 > 32'(FRAME_BYTES)
                                        || cnt32 < 32'd1 || cnt32 > lim32) begin
                                    r_code <= EXC_ILL_VALUE;
                                end else if (start32 >= lim32 || start32 + cnt32 > lim32) begin
                                    r_code <= EXC_ILL_ADDR;
                                end else begin
                                    r_kind <= K_READ;
                                    r_body <= 9'(32'd3 + 2 * cnt32);
                                end
                            end
                            FN_WRITE_ONE: begin
                                if (len32 != 32'd8) begin
                                    r_code <= EXC_ILL_VALUE;
                                end else if (start32 >= lim32) begin
                                    r_code <= EXC_ILL_ADDR;
                                end else begin
                                    r_kind <= K_ECHO;
                                    r_body <= 9'd6;
                                end
                            end
                            FN_WRITE_MULT: begin
                                if (len32 < 32'd9
                                        || 32'd9 + bc32 > 32'(FRAME_BYTES)
                                        || len32 != 32'd9 + bc32
                                        || cnt32 < 32'd1 || cnt32 > 32'(MAX_WR_CNT)
                                        || bc32 != 2 * cnt32) begin
                                    r_code <= EXC_ILL_VALUE;
                                end else if (start32 >= lim32 || start32 + cnt32 > lim32) begin
                                    r_code <= EXC_ILL_ADDR;
                                end else begin
                                    r_kind <= K_ECHO;
                                    r_body <= 9'd6;
                                    r_st   <= S_WRD;
                                    r_j    <= LEN_W'(7);
                                    r_ph   <= 1'b0;
                                    r_widx <= RA_W'(start32);
                                    r_len  <= r_len;
                                end
                            end
                            default: r_code <= EXC_ILL_FUNC;
                        endcase
                    end
                end
                S_WRD: r_st <= S_WGET;
                S_WGET: begin
                    r_ph <= !r_ph;
                    r_j  <= r_j + LEN_W'(1);
                    r_st <= S_WRD;
                    if (!r_ph) begin
                        r_hi <= r_frm_rd;
                    end else begin
                        r_widx <= r_widx + RA_W'(1);
                        if (r_j == r_len - LEN_W'(3)) begin
                            r_len <= '0;
                            r_st  <= r_bcast ? S_IDLE : S_TX;
                        end
                    end
                end
                S_TX: begin
                    if (need_fetch) begin
                        r_st <= S_RFETCH;
                    end else if (slot_free) begin
                        o_m_tvalid <= ovalid_n;
                        o_m_tdata  <= obyte_n;
                        o_m_tlast  <= olast_n;
                        r_tidx     <= r_tidx + 9'd1;
                        if (r_tidx < r_body) r_tcrc <= crc_byte(r_tcrc, obyte_n);
                        if ((r_kind == K_READ) && (r_tidx >= 9'd3) && off[0]) r_have <= 1'b0;
                        if (olast_n) r_st <= S_IDLE;
                    end
                end
                S_RFETCH: begin
                    r_have <= 1'b1;
                    r_st   <= S_TX;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/modbus_rtu_slave_engine_core.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_engine_core
// Modbus RTU slave: frame collection, CRC check and holding-register service.
// ----------------------------------------------------------------------------
// Slave stream: one item per received byte (tuser = 0, tdata = byte) or a
// frame gap (tuser = 1). Master stream: response bytes, tlast on the CRC high
// byte. Byte items are absorbed while the engine is idle. At a gap the engine
// reads the frame buffer once to check CRC and capture the header, runs the
// checks, writes multi-write data to the registers through its read and get
// states, then emits any response one byte per cycle while tready is high,
// with a fetch state before each register read. A four-item queue in front
// keeps taking bytes meanwhile. After reset the register file is cleared
// with tready low; configuration writes are taken throughout. When the
// receiver holds tready low the output register holds its byte and the
// engine waits; the input queue still fills until full.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_engine_core #(
    parameter int FRAME_BYTES = 64,
    parameter int REG_DEPTH   = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // rx_byte
    input  logic       i_s_tuser,   // mode
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // tx_byte
    output logic       o_m_tlast,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata
);
    import mrse_pkg::*;

    t_q_out q;
    t_q_ctl ctl;

    mrse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_ctl      (ctl),
        .o_q        (q)
    );

    mrse_engine #(
        .FRAME_BYTES (FRAME_BYTES),
        .REG_DEPTH   (REG_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q),
        .o_ctl       (ctl),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

### hdl/mrse_checker.sv
// ----------------------------------------------------------------------------
// mrse_checker
// Port-level checks on the slave engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "modbus_rtu_slave_engine_core_assert.svh"

module mrse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // stalled response byte holds
    `MRSE_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
    // no response byte right after reset
    `MRSE_ASSERT(a_rst_no_out, i_clk, !i_rst_n |=> !o_m_tvalid)
    // register clear keeps the input closed after reset
    `MRSE_ASSERT(a_rst_closed, i_clk, !i_rst_n |=> !o_s_tready)

endmodule

bind modbus_rtu_slave_engine_core mrse_checker u_mrse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
